@@ rtl/core/exptok_pkg.sv @@
// ============================================================================
// exptok_pkg
// Shared types, codes and lookup functions of the expression tokenizer.
// ============================================================================
package exptok_pkg;

  // Position counter width and depth of the identifier name buffer
  localparam int POS_W      = 16;
  localparam int NAME_LEN   = 5;
  localparam int NAME_IDX_W = $clog2(NAME_LEN);

  // Result field widths
  localparam int KIND_W = 6;
  localparam int OFS_W  = 16;
  localparam int ERR_W  = 2;

  // Token kinds
  localparam logic [KIND_W-1:0] KIND_NUMBER  = 6'd0;
  localparam logic [KIND_W-1:0] KIND_SYMBOL  = 6'd1;
  localparam logic [KIND_W-1:0] KIND_FUNC0   = 6'd2;
  localparam logic [KIND_W-1:0] KIND_GE      = 6'd18;
  localparam logic [KIND_W-1:0] KIND_LE      = 6'd19;
  localparam logic [KIND_W-1:0] KIND_EQ      = 6'd20;
  localparam logic [KIND_W-1:0] KIND_SINGLE0 = 6'd21;
  localparam logic [KIND_W-1:0] KIND_LT      = 6'd39;
  localparam logic [KIND_W-1:0] KIND_GT      = 6'd40;

  // Error codes
  localparam logic [ERR_W-1:0] ERR_OK      = 2'd0;
  localparam logic [ERR_W-1:0] ERR_UNKNOWN = 2'd1;
  localparam logic [ERR_W-1:0] ERR_LONG    = 2'd2;

  // Open run classes
  localparam logic [1:0] CLS_NONE  = 2'd0;
  localparam logic [1:0] CLS_NUM   = 2'd1;
  localparam logic [1:0] CLS_IDENT = 2'd2;

  // Pending first characters of two-character operators
  localparam logic [1:0] PEND_NONE = 2'd0;
  localparam logic [1:0] PEND_GT   = 2'd1;
  localparam logic [1:0] PEND_LT   = 2'd2;
  localparam logic [1:0] PEND_EQ   = 2'd3;

  // Character codes
  localparam logic [7:0] CH_ZERO  = "0";
  localparam logic [7:0] CH_NINE  = "9";
  localparam logic [7:0] CH_LOW_A = "a";
  localparam logic [7:0] CH_LOW_Z = "z";
  localparam logic [7:0] CH_UNDER = "_";
  localparam logic [7:0] CH_GT    = ">";
  localparam logic [7:0] CH_LT    = "<";
  localparam logic [7:0] CH_EQ    = "=";
  localparam logic [7:0] CH_SPACE = " ";
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  // Built-in function names, right-justified: first character in the highest used byte
  localparam int FUNC_NUM   = 16;
  localparam int FUNC_CHARS = 5;

  typedef logic [FUNC_CHARS*8-1:0] fname_t;
  typedef logic [NAME_LEN-1:0][7:0] name_buf_t;

  localparam fname_t FUNC_NAMES [FUNC_NUM] = '{
    40'("sin"),   40'("cos"),   40'("tan"),   40'("asin"),
    40'("acos"),  40'("atan"),  40'("sinh"),  40'("cosh"),
    40'("tanh"),  40'("asinh"), 40'("acosh"), 40'("atanh"),
    40'("log"),   40'("exp"),   40'("pow"),   40'("sqrt")
  };
  localparam logic [2:0] FUNC_LENS [FUNC_NUM] = '{
    3'd3, 3'd3, 3'd3, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4,
    3'd4, 3'd5, 3'd5, 3'd5, 3'd3, 3'd3, 3'd3, 3'd4
  };

  // Single-character operators and punctuation, in kind order
  localparam int SINGLE_NUM = 21;
  localparam logic [7:0] SINGLE_OPS [SINGLE_NUM] = '{
    "(", ")", "[", "]", "{", "}", ":", ";", ".", ",", 8'h22, 8'h27,
    "+", "-", "*", "/", "^", "%", "<", ">", "!"
  };

  // One result beat
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [OFS_W-1:0]  start;
    logic [OFS_W-1:0]  len;
    logic [ERR_W-1:0]  err;
    logic              last;
  } res_t;

  function automatic res_t mk_res(input logic [KIND_W-1:0] kind,
                                  input logic [POS_W-1:0]  start,
                                  input logic [POS_W-1:0]  len,
                                  input logic [ERR_W-1:0]  err);
    res_t r;
    r.kind  = kind;
    r.start = OFS_W'(start);
    r.len   = OFS_W'(len);
    r.err   = err;
    r.last  = 1'b0;
    return r;
  endfunction

  // Kind of a closed identifier run: a function when the name matches, else a symbol
  function automatic logic [KIND_W-1:0] ident_kind(input name_buf_t nb,
                                                   input logic [POS_W-1:0] len);
    logic [KIND_W-1:0] kind;
    logic              hit;
    int                pos;
    kind = KIND_SYMBOL;
    for (int i = FUNC_NUM - 1; i >= 0; i--) begin
      hit = (len == POS_W'(FUNC_LENS[i]));
      for (int k = 0; k < FUNC_CHARS; k++) begin
        if (k < int'(FUNC_LENS[i])) begin
          pos = int'(FUNC_LENS[i]) - 1 - k;
          if (nb[k] != FUNC_NAMES[i][pos*8 +: 8]) hit = 1'b0;
        end
      end
      if (hit) kind = KIND_FUNC0 + KIND_W'(i);
    end
    return kind;
  endfunction

  // Kind of a single-character operator; KIND_NUMBER when the byte is none
  function automatic logic [KIND_W-1:0] single_kind(input logic [7:0] b);
    logic [KIND_W-1:0] kind;
    kind = KIND_NUMBER;
    for (int i = SINGLE_NUM - 1; i >= 0; i--) begin
      if (b == SINGLE_OPS[i]) kind = KIND_SINGLE0 + KIND_W'(i);
    end
    return kind;
  endfunction

endpackage

@@ rtl/core/expression_tokenizer.sv @@
// ============================================================================
// expression_tokenizer
// Streaming maximal-munch lexer: one text byte in per beat, tokens out.
// ============================================================================
// The block takes one text byte per cycle and returns the tokens that byte
// completes, one output beat per token. A byte completes at most two tokens.
// Results are registered into a three-entry result queue before they appear
// on the output, and in_tready drops while two or more results wait in it. A
// byte that completes two tokens therefore holds the input off while its
// second token drains, and for longer while the output stalls. Bytes that
// complete one token or none are taken every cycle while the output is ready.
// The token kind travels on out_tuser. out_tlast marks the last result caused
// by one input byte. in_tlast marks the final byte of a text: unless an error
// has been reported, it flushes any open token, and it returns the block to
// its reset state.
module expression_tokenizer
  import exptok_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] text_byte
  input  logic        in_tlast,   // end_of_text
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [15:0] token_start, [31:16] token_length,
                                  // [33:32] error_code, [39:34] zero
  output logic [5:0]  out_tuser,  // [5:0] token_kind
  output logic        out_tlast   // run_last
);

  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

  // Lexer state
  logic [1:0]       cls_r,   cls_nxt;
  logic [POS_W-1:0] start_r, start_nxt;
  logic [POS_W-1:0] len_r,   len_nxt;
  logic [1:0]       pend_r,  pend_nxt;
  logic [POS_W-1:0] pos_r,   pos_nxt;
  logic             err_r,   err_nxt;
  name_buf_t        nbuf_r,  nbuf_nxt;

  // Result queue
  res_t             q_r [3];
  res_t             q_nxt [3];
  logic [1:0]       cnt_r, cnt_nxt;

  // Step results
  res_t             res_v [2];
  logic [1:0]       nres;
  logic [1:0]       cls_in;
  logic             consumed;
  logic             accept;
  logic             pop;
  logic [7:0]       b;
  logic             last;
  logic [KIND_W-1:0] op_kind;

  assign b      = in_tdata;
  assign last   = in_tlast;
  assign accept = in_tvalid & in_tready;
  assign pop    = out_tvalid & out_tready;

  assign in_tready  = (cnt_r <= 2'd1);
  assign out_tvalid = (cnt_r != 2'd0);
  assign out_tdata  = {6'd0, q_r[0].err, q_r[0].len, q_r[0].start};
  assign out_tuser  = q_r[0].kind;
  assign out_tlast  = q_r[0].last;

  // Classify the byte
  always_comb begin
    cls_in = CLS_NONE;
    if (b >= CH_ZERO && b <= CH_NINE) begin
      cls_in = CLS_NUM;
    end else if ((b >= CH_LOW_A && b <= CH_LOW_Z) || b == CH_UNDER) begin
      cls_in = CLS_IDENT;
    end
  end

  assign op_kind = single_kind(b);

  // Work out the results and next state for the incoming byte
  always_comb begin
    cls_nxt   = cls_r;
    start_nxt = start_r;
    len_nxt   = len_r;
    pend_nxt  = pend_r;
    pos_nxt   = pos_r;
    err_nxt   = err_r;
    nbuf_nxt  = nbuf_r;
    nres      = 2'd0;
    consumed  = 1'b0;
    res_v[0]  = mk_res(KIND_NUMBER, '0, '0, ERR_OK);
    res_v[1]  = mk_res(KIND_NUMBER, '0, '0, ERR_OK);

    if (!err_r) begin
      if (pos_r == POS_MAX) begin
        // Text too long: report, drop the open run and pending operator
        res_v[nres[0]] = mk_res(KIND_NUMBER, pos_r, '0, ERR_LONG);
        nres     = nres + 2'd1;
        err_nxt  = 1'b1;
        cls_nxt  = CLS_NONE;
        pend_nxt = PEND_NONE;
      end else begin
        // Resolve a pending '>', '<' or '='
        if (pend_nxt != PEND_NONE) begin
          if (b == CH_EQ) begin
            unique case (pend_nxt)
              PEND_GT: res_v[nres[0]] = mk_res(KIND_GE, pos_r - 1'b1, POS_W'(2), ERR_OK);
              PEND_LT: res_v[nres[0]] = mk_res(KIND_LE, pos_r - 1'b1, POS_W'(2), ERR_OK);
              default: res_v[nres[0]] = mk_res(KIND_EQ, pos_r - 1'b1, POS_W'(2), ERR_OK);
            endcase
            nres     = nres + 2'd1;
            consumed = 1'b1;
          end else if (pend_nxt == PEND_EQ) begin
            res_v[nres[0]] = mk_res(KIND_NUMBER, pos_r - 1'b1, '0, ERR_UNKNOWN);
            nres     = nres + 2'd1;
            err_nxt  = 1'b1;
            consumed = 1'b1;
          end else begin
            res_v[nres[0]] = mk_res((pend_nxt == PEND_GT) ? KIND_GT : KIND_LT,
                                    pos_r - 1'b1, POS_W'(1), ERR_OK);
            nres = nres + 2'd1;
          end
          pend_nxt = PEND_NONE;
        end

        if (!consumed) begin
          if (cls_in != CLS_NONE) begin
            // Extend or start a run
            if (cls_nxt != cls_in) begin
              if (cls_nxt == CLS_NUM) begin
                res_v[nres[0]] = mk_res(KIND_NUMBER, start_nxt, len_nxt, ERR_OK);
                nres = nres + 2'd1;
              end else if (cls_nxt == CLS_IDENT) begin
                res_v[nres[0]] = mk_res(ident_kind(nbuf_nxt, len_nxt), start_nxt,
                                        len_nxt, ERR_OK);
                nres = nres + 2'd1;
              end
              cls_nxt   = cls_in;
              start_nxt = pos_r;
              len_nxt   = '0;
            end
            if (cls_in == CLS_IDENT && len_nxt < POS_W'(NAME_LEN)) begin
              nbuf_nxt[len_nxt[NAME_IDX_W-1:0]] = b;
            end
            len_nxt = len_nxt + 1'b1;
          end else begin
            // Close the open run
            if (cls_nxt == CLS_NUM) begin
              res_v[nres[0]] = mk_res(KIND_NUMBER, start_nxt, len_nxt, ERR_OK);
              nres = nres + 2'd1;
            end else if (cls_nxt == CLS_IDENT) begin
              res_v[nres[0]] = mk_res(ident_kind(nbuf_nxt, len_nxt), start_nxt,
                                      len_nxt, ERR_OK);
              nres = nres + 2'd1;
            end
            cls_nxt = CLS_NONE;
            // Operators, whitespace and unknown characters
            if (b == CH_GT) begin
              pend_nxt = PEND_GT;
            end else if (b == CH_LT) begin
              pend_nxt = PEND_LT;
            end else if (b == CH_EQ) begin
              pend_nxt = PEND_EQ;
            end else if (b == CH_SPACE || (b >= CH_TAB && b <= CH_CR)) begin
              // skip whitespace
            end else if (op_kind != KIND_NUMBER) begin
              res_v[nres[0]] = mk_res(op_kind, pos_r, POS_W'(1), ERR_OK);
              nres = nres + 2'd1;
            end else begin
              res_v[nres[0]] = mk_res(KIND_NUMBER, pos_r, '0, ERR_UNKNOWN);
              nres    = nres + 2'd1;
              err_nxt = 1'b1;
            end
          end
        end

        if (!err_nxt) pos_nxt = pos_r + 1'b1;
      end

      // End of text: flush the open run and a pending operator
      if (last && !err_nxt) begin
        if (cls_nxt == CLS_NUM) begin
          res_v[nres[0]] = mk_res(KIND_NUMBER, start_nxt, len_nxt, ERR_OK);
          nres = nres + 2'd1;
        end else if (cls_nxt == CLS_IDENT) begin
          res_v[nres[0]] = mk_res(ident_kind(nbuf_nxt, len_nxt), start_nxt,
                                  len_nxt, ERR_OK);
          nres = nres + 2'd1;
        end
        if (pend_nxt == PEND_GT) begin
          res_v[nres[0]] = mk_res(KIND_GT, pos_r, POS_W'(1), ERR_OK);
          nres = nres + 2'd1;
        end else if (pend_nxt == PEND_LT) begin
          res_v[nres[0]] = mk_res(KIND_LT, pos_r, POS_W'(1), ERR_OK);
          nres = nres + 2'd1;
        end else if (pend_nxt == PEND_EQ) begin
          res_v[nres[0]] = mk_res(KIND_NUMBER, pos_r, '0, ERR_UNKNOWN);
          nres = nres + 2'd1;
        end
      end
    end

    // Mark the last result of this byte
    if (nres == 2'd1) res_v[0].last = 1'b1;
    if (nres == 2'd2) res_v[1].last = 1'b1;

    // Back to reset state after the final byte
    if (last) begin
      cls_nxt   = CLS_NONE;
      start_nxt = '0;
      len_nxt   = '0;
      pend_nxt  = PEND_NONE;
      pos_nxt   = '0;
      err_nxt   = 1'b0;
    end
  end

  // Drop the head on a taken beat, append this byte's results behind
  always_comb begin
    q_nxt   = q_r;
    cnt_nxt = cnt_r;
    if (pop) begin
      q_nxt[0] = q_r[1];
      q_nxt[1] = q_r[2];
      cnt_nxt  = cnt_r - 2'd1;
    end
    if (accept) begin
      if (nres != 2'd0) q_nxt[cnt_nxt] = res_v[0];
      if (nres == 2'd2) q_nxt[cnt_nxt + 2'd1] = res_v[1];
      cnt_nxt = cnt_nxt + nres;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cls_r   <= CLS_NONE;
      start_r <= '0;
      len_r   <= '0;
      pend_r  <= PEND_NONE;
      pos_r   <= '0;
      err_r   <= 1'b0;
      cnt_r   <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (accept) begin
        cls_r   <= cls_nxt;
        start_r <= start_nxt;
        len_r   <= len_nxt;
        pend_r  <= pend_nxt;
        pos_r   <= pos_nxt;
        err_r   <= err_nxt;
      end
    end
  end

  // Payload: name buffer and result queue
  always_ff @(posedge clk) begin
    if (accept) nbuf_r <= nbuf_nxt;
    q_r <= q_nxt;
  end

endmodule
